### hw/rtl/p2x_pkg.sv
`default_nettype none
package p2x_pkg;

  localparam int unsigned PixW = 16;
  localparam int unsigned RowW = 4 * PixW;

  localparam logic [PixW-1:0] HalfMask565     = 16'hF7DE;
  localparam logic [PixW-1:0] HalfLowMask565  = 16'h0821;
  localparam logic [PixW-1:0] QuarMask565     = 16'hE79C;
  localparam logic [PixW-1:0] QuarLowMask565  = 16'h1863;
  localparam logic [PixW-1:0] HalfMask555     = 16'h7BDE;
  localparam logic [PixW-1:0] HalfLowMask555  = 16'h0421;
  localparam logic [PixW-1:0] QuarMask555     = 16'h739C;
  localparam logic [PixW-1:0] QuarLowMask555  = 16'h0C63;

  typedef enum logic [0:0] {
    FMT_RGB565 = 1'b0,
    FMT_RGB555 = 1'b1
  } color_fmt_t;

  typedef logic [PixW-1:0] pixel_t;

  // source of one output pixel
  typedef enum logic [2:0] {
    SEL_A      = 3'd0,
    SEL_B      = 3'd1,
    SEL_C      = 3'd2,
    SEL_AVG_AB = 3'd3,
    SEL_AVG_AC = 3'd4,
    SEL_AVG4   = 3'd5
  } pix_sel_t;

  // equality compares over the 4x4 window
  typedef struct packed {
    logic eq_ad, eq_bc, eq_ae, eq_bl, eq_ac, eq_af, eq_be, eq_bj;
    logic eq_ag, eq_co, eq_ab, eq_ah, eq_gc, eq_cm, eq_bf, eq_ch;
    logic eq_cg, eq_cd, eq_bd, eq_ai, eq_bg, eq_bk, eq_ak, eq_bh;
    logic eq_bn, eq_an, eq_al, eq_ao, eq_bo;
  } eq_flags_t;

  function automatic pixel_t avg2(input pixel_t a, input pixel_t b, input color_fmt_t fmt);
    pixel_t m;
    pixel_t ml;
    logic [PixW:0] sum;
    m   = (fmt == FMT_RGB555) ? HalfMask555 : HalfMask565;
    ml  = (fmt == FMT_RGB555) ? HalfLowMask555 : HalfLowMask565;
    sum = {1'b0, (a & m) >> 1} + {1'b0, (b & m) >> 1} + {1'b0, a & b & ml};
    if (a == b) begin
      return a;
    end
    return sum[PixW-1:0];
  endfunction

  function automatic pixel_t avg4(input pixel_t a, input pixel_t b, input pixel_t c,
                                  input pixel_t d, input color_fmt_t fmt);
    pixel_t qm;
    pixel_t ql;
    logic [PixW+1:0] hi;
    logic [PixW+1:0] lo_sum;
    pixel_t lo;
    logic [PixW+1:0] tot;
    qm     = (fmt == FMT_RGB555) ? QuarMask555 : QuarMask565;
    ql     = (fmt == FMT_RGB555) ? QuarLowMask555 : QuarLowMask565;
    hi     = {2'b0, (a & qm) >> 2} + {2'b0, (b & qm) >> 2}
           + {2'b0, (c & qm) >> 2} + {2'b0, (d & qm) >> 2};
    lo_sum = {2'b0, a & ql} + {2'b0, b & ql} + {2'b0, c & ql} + {2'b0, d & ql};
    lo     = lo_sum[PixW+1:2] & ql;
    tot    = hi + {2'b0, lo};
    return tot[PixW-1:0];
  endfunction

  // +1 when both neighbours match the second colour only, -1 when both match the first
  function automatic logic signed [1:0] score(input logic eq_ac, input logic eq_ad,
                                              input logic eq_bc, input logic eq_bd);
    if ((eq_bc && !eq_ac) && (eq_bd && !eq_ad)) begin
      return 2'sd1;
    end
    if (eq_ac && eq_ad) begin
      return -2'sd1;
    end
    return 2'sd0;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/p2x_if.sv
`default_nettype none
interface p2x_in_if
  import p2x_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [RowW-1:0] row_above;
  logic [RowW-1:0] row_current;
  logic [RowW-1:0] row_below;
  logic [RowW-1:0] row_two_below;

  modport source (output valid, row_above, row_current, row_below, row_two_below,
                  input ready);
  modport sink   (input valid, row_above, row_current, row_below, row_two_below,
                  output ready);
endinterface

interface p2x_out_if
  import p2x_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] top_left;
  logic [PixW-1:0] top_right;
  logic [PixW-1:0] bottom_left;
  logic [PixW-1:0] bottom_right;

  modport source (output valid, top_left, top_right, bottom_left, bottom_right,
                  input ready);
  modport sink   (input valid, top_left, top_right, bottom_left, bottom_right,
                  output ready);
endinterface

interface p2x_cfg_if;
  logic valid;
  logic ready;
  logic color_format;

  modport source (output valid, color_format, input ready);
  modport sink   (input valid, color_format, output ready);
endinterface
`default_nettype wire

### hw/rtl/pixel_art_upscale_2xsai.sv
// 2xSaI pixel doubler: each transaction on pix_in carries the 4x4 window around one
// 16-bit source pixel (four packed rows, leftmost column in the low bits) and produces
// one transaction on pix_out with the 2x2 output block. A new window is taken every
// clock unless pix_out stalls; results pass through the compare/average stage, the
// edge-vote stage and the output select register. Back-pressure on pix_out stalls the
// pipeline stage by stage without loss. cfg selects RGB565 (0) or RGB555 (1) masks and
// is always ready; change it only while the pipeline is empty.
`default_nettype none
module pixel_art_upscale_2xsai
  import p2x_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  p2x_in_if.sink     pix_in,
  p2x_out_if.source  pix_out,
  p2x_cfg_if.sink    cfg
);

  color_fmt_t color_format;

  logic v1, v2, v3;
  logic en1, en2, en3;

  // stage 1
  eq_flags_t f1;
  pixel_t    a1, b1, c1, avg_ab1, avg_ac1, avg4_1;
  // stage 2
  pixel_t    a2, b2, c2, avg_ab2, avg_ac2, avg4_2;
  pix_sel_t  tr_sel, bl_sel, br_sel;
  // stage 3
  pixel_t    out_tl, out_tr, out_bl, out_br;

  pixel_t    pi, pe, pf, pj, pg, pa, pb, pk, ph, pc, pd, pl, pm, pn, po;
  eq_flags_t f_next;
  pix_sel_t  tr_sel_next, bl_sel_next, br_sel_next;
  logic signed [3:0] vote;

  assign en3 = !v3 || pix_out.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign pix_in.ready = en1;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_format <= FMT_RGB565;
    end else if (cfg.valid) begin
      color_format <= color_fmt_t'(cfg.color_format);
    end
  end

  always_comb begin
    pi = pix_in.row_above[0*PixW +: PixW];
    pe = pix_in.row_above[1*PixW +: PixW];
    pf = pix_in.row_above[2*PixW +: PixW];
    pj = pix_in.row_above[3*PixW +: PixW];
    pg = pix_in.row_current[0*PixW +: PixW];
    pa = pix_in.row_current[1*PixW +: PixW];
    pb = pix_in.row_current[2*PixW +: PixW];
    pk = pix_in.row_current[3*PixW +: PixW];
    ph = pix_in.row_below[0*PixW +: PixW];
    pc = pix_in.row_below[1*PixW +: PixW];
    pd = pix_in.row_below[2*PixW +: PixW];
    pl = pix_in.row_below[3*PixW +: PixW];
    pm = pix_in.row_two_below[0*PixW +: PixW];
    pn = pix_in.row_two_below[1*PixW +: PixW];
    po = pix_in.row_two_below[2*PixW +: PixW];

    f_next.eq_ad = (pa == pd);
    f_next.eq_bc = (pb == pc);
    f_next.eq_ae = (pa == pe);
    f_next.eq_bl = (pb == pl);
    f_next.eq_ac = (pa == pc);
    f_next.eq_af = (pa == pf);
    f_next.eq_be = (pb == pe);
    f_next.eq_bj = (pb == pj);
    f_next.eq_ag = (pa == pg);
    f_next.eq_co = (pc == po);
    f_next.eq_ab = (pa == pb);
    f_next.eq_ah = (pa == ph);
    f_next.eq_gc = (pg == pc);
    f_next.eq_cm = (pc == pm);
    f_next.eq_bf = (pb == pf);
    f_next.eq_ch = (pc == ph);
    f_next.eq_cg = (pc == pg);
    f_next.eq_cd = (pc == pd);
    f_next.eq_bd = (pb == pd);
    f_next.eq_ai = (pa == pi);
    f_next.eq_bg = (pb == pg);
    f_next.eq_bk = (pb == pk);
    f_next.eq_ak = (pa == pk);
    f_next.eq_bh = (pb == ph);
    f_next.eq_bn = (pb == pn);
    f_next.eq_an = (pa == pn);
    f_next.eq_al = (pa == pl);
    f_next.eq_ao = (pa == po);
    f_next.eq_bo = (pb == po);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      f1      <= f_next;
      a1      <= pa;
      b1      <= pb;
      c1      <= pc;
      avg_ab1 <= avg2(pa, pb, color_format);
      avg_ac1 <= avg2(pa, pc, color_format);
      avg4_1  <= avg4(pa, pb, pc, pd, color_format);
    end
  end

  // edge vote, only meaningful when both diagonals match and A differs from B
  always_comb begin
    vote = 4'(score(f1.eq_ag, f1.eq_ae, f1.eq_bg, f1.eq_be))
         - 4'(score(f1.eq_bk, f1.eq_bf, f1.eq_ak, f1.eq_af))
         - 4'(score(f1.eq_bh, f1.eq_bn, f1.eq_ah, f1.eq_an))
         + 4'(score(f1.eq_al, f1.eq_ao, f1.eq_bl, f1.eq_bo));
  end

  always_comb begin
    tr_sel_next = SEL_AVG_AB;
    bl_sel_next = SEL_AVG_AC;
    br_sel_next = SEL_AVG4;
    if (f1.eq_ad && !f1.eq_bc) begin
      if ((f1.eq_ae && f1.eq_bl) ||
          (f1.eq_ac && f1.eq_af && !f1.eq_be && f1.eq_bj)) begin
        tr_sel_next = SEL_A;
      end
      if ((f1.eq_ag && f1.eq_co) ||
          (f1.eq_ab && f1.eq_ah && !f1.eq_gc && f1.eq_cm)) begin
        bl_sel_next = SEL_A;
      end
      br_sel_next = SEL_A;
    end else if (f1.eq_bc && !f1.eq_ad) begin
      if ((f1.eq_bf && f1.eq_ah) ||
          (f1.eq_be && f1.eq_bd && !f1.eq_af && f1.eq_ai)) begin
        tr_sel_next = SEL_B;
      end
      if ((f1.eq_ch && f1.eq_af) ||
          (f1.eq_cg && f1.eq_cd && !f1.eq_ah && f1.eq_ai)) begin
        bl_sel_next = SEL_C;
      end
      br_sel_next = SEL_B;
    end else if (f1.eq_ad && f1.eq_bc) begin
      if (f1.eq_ab) begin
        tr_sel_next = SEL_A;
        bl_sel_next = SEL_A;
        br_sel_next = SEL_A;
      end else if (vote > 4'sd0) begin
        br_sel_next = SEL_A;
      end else if (vote < 4'sd0) begin
        br_sel_next = SEL_B;
      end
    end else begin
      if (f1.eq_ac && f1.eq_af && !f1.eq_be && f1.eq_bj) begin
        tr_sel_next = SEL_A;
      end else if (f1.eq_be && f1.eq_bd && !f1.eq_af && f1.eq_ai) begin
        tr_sel_next = SEL_B;
      end
      if (f1.eq_ab && f1.eq_ah && !f1.eq_gc && f1.eq_cm) begin
        bl_sel_next = SEL_A;
      end else if (f1.eq_cg && f1.eq_cd && !f1.eq_ah && f1.eq_ai) begin
        bl_sel_next = SEL_C;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      a2      <= a1;
      b2      <= b1;
      c2      <= c1;
      avg_ab2 <= avg_ab1;
      avg_ac2 <= avg_ac1;
      avg4_2  <= avg4_1;
      tr_sel  <= tr_sel_next;
      bl_sel  <= bl_sel_next;
      br_sel  <= br_sel_next;
    end
  end

  function automatic pixel_t pick(input pix_sel_t sel, input pixel_t a, input pixel_t b,
                                  input pixel_t c, input pixel_t ab, input pixel_t ac,
                                  input pixel_t q);
    pixel_t r;
    case (sel)
      SEL_A:      r = a;
      SEL_B:      r = b;
      SEL_C:      r = c;
      SEL_AVG_AB: r = ab;
      SEL_AVG_AC: r = ac;
      SEL_AVG4:   r = q;
      default:    r = a;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_tl <= a2;
      out_tr <= pick(tr_sel, a2, b2, c2, avg_ab2, avg_ac2, avg4_2);
      out_bl <= pick(bl_sel, a2, b2, c2, avg_ab2, avg_ac2, avg4_2);
      out_br <= pick(br_sel, a2, b2, c2, avg_ab2, avg_ac2, avg4_2);
    end
  end

  assign pix_out.valid        = v3;
  assign pix_out.top_left     = out_tl;
  assign pix_out.top_right    = out_tr;
  assign pix_out.bottom_left  = out_bl;
  assign pix_out.bottom_right = out_br;

  // input back-pressure only when every stage holds a transaction
  assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> (v1 && v2 && v3))
    else $error("input stalled with a free pipeline stage");

  assert property (@(posedge clk) disable iff (rst)
    (pix_in.valid && pix_in.ready) |=> v1)
    else $error("accepted transaction lost at stage 1");

  // a stalled output stage keeps its transaction until taken
  assert property (@(posedge clk) disable iff (rst)
    (v3 && !pix_out.ready) |=> (v3 && $stable(out_br) && $stable(out_tr)))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    v2 |-> (br_sel != SEL_C && br_sel != SEL_AVG_AB && br_sel != SEL_AVG_AC))
    else $error("illegal lower-right source");

endmodule
`default_nettype wire
